// File: sv/dfed_pkg.sv
// Package for the DALI frame event decoder.
// Field widths, code enums and the result struct; no dependencies.
package dfed_pkg;

  localparam int unsigned FrameBitsW  = 6;
  localparam int unsigned FrameDataW  = 32;
  localparam int unsigned AddrW       = 6;
  localparam int unsigned PayloadW    = 10;
  localparam int unsigned MaskW       = 5;
  localparam int unsigned Field5W     = 5;

  localparam logic [FrameBitsW-1:0] LenForward = 6'd16;
  localparam logic [FrameBitsW-1:0] LenEvent   = 6'd24;

  localparam logic [10:0] PowerTag    = 11'h7F7;
  localparam logic [7:0]  ShortMax    = 8'h7F;
  localparam logic [7:0]  GroupMax    = 8'h9F;
  localparam logic [7:0]  BcastLow    = 8'hFE;

  localparam logic [MaskW-1:0] MaskDevice    = 5'h01;
  localparam logic [MaskW-1:0] MaskGroup     = 5'h02;
  localparam logic [MaskW-1:0] MaskDevInst   = 5'h09;
  localparam logic [MaskW-1:0] MaskDevType   = 5'h05;
  localparam logic [MaskW-1:0] MaskGrpType   = 5'h06;
  localparam logic [MaskW-1:0] MaskInstance  = 5'h0C;
  localparam logic [MaskW-1:0] MaskInstGroup = 5'h16;

  typedef enum logic [1:0] {
    FK_INVALID = 2'd0,
    FK_FORWARD = 2'd1,
    FK_EVENT   = 2'd2,
    FK_POWER   = 2'd3
  } frm_kind_e;

  typedef enum logic [1:0] {
    AK_NONE  = 2'd0,
    AK_SHORT = 2'd1,
    AK_GROUP = 2'd2,
    AK_BCAST = 2'd3
  } addr_kind_e;

  typedef enum logic [2:0] {
    SS_NONE       = 3'd0,
    SS_DEVICE     = 3'd1,
    SS_DEV_INST   = 3'd2,
    SS_DEV_GROUP  = 3'd3,
    SS_INSTANCE   = 3'd4,
    SS_INST_GROUP = 3'd5,
    SS_POWER      = 3'd6
  } src_scheme_e;

  typedef struct packed {
    logic                status;
    frm_kind_e           frm_kind;
    addr_kind_e          adr_kind;
    logic [AddrW-1:0]    target_address;
    logic                selector_bit;
    logic [PayloadW-1:0] payload;
    src_scheme_e         source_scheme;
    logic [MaskW-1:0]    present_mask;
    logic [AddrW-1:0]    source_address;
    logic [Field5W-1:0]  source_group;
    logic [Field5W-1:0]  inst_type;
    logic [Field5W-1:0]  instance_number;
  } result_t;

endpackage

// File: sv/dfed_if.sv
// Valid/ready channel interfaces for frames in and decode results out.
// Depends on dfed_pkg for field widths.
interface dfed_frame_if;
  import dfed_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FrameBitsW-1:0] frame_bits;
  logic [FrameDataW-1:0] frame_data;

  modport source (output valid, output frame_bits, output frame_data, input ready);
  modport sink   (input valid, input frame_bits, input frame_data, output ready);
endinterface

interface dfed_result_if;
  import dfed_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic [1:0]          frm_kind;
  logic [1:0]          adr_kind;
  logic [AddrW-1:0]    target_address;
  logic                selector_bit;
  logic [PayloadW-1:0] payload;
  logic [2:0]          source_scheme;
  logic [MaskW-1:0]    present_mask;
  logic [AddrW-1:0]    source_address;
  logic [Field5W-1:0]  source_group;
  logic [Field5W-1:0]  inst_type;
  logic [Field5W-1:0]  instance_number;

  modport source (
    output valid, output status, output frm_kind, output adr_kind,
    output target_address, output selector_bit, output payload, output source_scheme,
    output present_mask, output source_address, output source_group,
    output inst_type, output instance_number, input ready
  );
  modport sink (
    input valid, input status, input frm_kind, input adr_kind,
    input target_address, input selector_bit, input payload, input source_scheme,
    input present_mask, input source_address, input source_group,
    input inst_type, input instance_number, output ready
  );
endinterface

// File: sv/dali_frame_event_decoder.sv
// Top level of the DALI frame event decoder: input register, decode, result register.
// Depends on dfed_pkg, dfed_if and dfed_decode.
//
// Usage:
//   frame_i carries one received frame (length in bits, right-aligned data);
//   result_o carries one classification per frame, in order.
//   A frame transfer registers the frame; from the input register it is decoded
//   and loaded into the result register once that register is free, and the
//   result is valid from that load until it transfers on result_o.
//   Both stages advance in the same cycle, so one frame per cycle is taken
//   as long as results are taken at that rate.
//   Throughput is one frame per cycle unless result_o stalls, set by the two register stages.
//   When result_o stalls, the result register holds and the input register
//   still takes one more frame; ready on frame_i drops only once both are full.
//   Reset empties both stages; no result is valid after reset.
//   Invalid frames give status 1 with every other field zero.
module dali_frame_event_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dfed_frame_if.sink           frame_i,
  dfed_result_if.source        result_o
);
  import dfed_pkg::*;

  logic                  in_vld_q;
  logic [FrameBitsW-1:0] in_bits_q;
  logic [FrameDataW-1:0] in_data_q;
  logic                  out_vld_q;
  result_t               out_q;
  result_t               dec_res;
  logic                  out_load;
  logic                  out_free;
  logic                  in_take;

  assign out_free = !out_vld_q || result_o.ready;
  assign out_load = in_vld_q && out_free;
  assign frame_i.ready = !in_vld_q || out_free;
  assign in_take = frame_i.valid && frame_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (frame_i.ready) begin
      in_vld_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_bits_q <= frame_i.frame_bits;
      in_data_q <= frame_i.frame_data;
    end
  end

  dfed_decode u_decode (
    .frame_bits_i (in_bits_q),
    .frame_data_i (in_data_q),
    .result_o     (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= dec_res;
    end
  end

  assign result_o.valid           = out_vld_q;
  assign result_o.status          = out_q.status;
  assign result_o.frm_kind        = out_q.frm_kind;
  assign result_o.adr_kind        = out_q.adr_kind;
  assign result_o.target_address  = out_q.target_address;
  assign result_o.selector_bit    = out_q.selector_bit;
  assign result_o.payload         = out_q.payload;
  assign result_o.source_scheme   = out_q.source_scheme;
  assign result_o.present_mask    = out_q.present_mask;
  assign result_o.source_address  = out_q.source_address;
  assign result_o.source_group    = out_q.source_group;
  assign result_o.inst_type       = out_q.inst_type;
  assign result_o.instance_number = out_q.instance_number;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status |->
      out_q.frm_kind == FK_INVALID && out_q.source_scheme == SS_NONE &&
      out_q.payload == '0 && out_q.present_mask == '0)
    else $error("invalid result carries nonzero fields");

  a_ok_has_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.status |-> out_q.frm_kind != FK_INVALID)
    else $error("ok result without a frame kind");

  a_forward_no_scheme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.frm_kind == FK_FORWARD |->
      out_q.source_scheme == SS_NONE && out_q.present_mask == '0)
    else $error("forward frame reports an event source");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q)
    else $error("decoded frame lost between stages");
`endif

endmodule

// File: sv/dfed_decode.sv
// Combinational classifier for one DALI frame: forward, input event or power notice.
// Depends on dfed_pkg for codes and the result struct.
module dfed_decode (
  input  logic [dfed_pkg::FrameBitsW-1:0] frame_bits_i,
  input  logic [dfed_pkg::FrameDataW-1:0] frame_data_i,
  output dfed_pkg::result_t               result_o
);
  import dfed_pkg::*;

  logic [7:0]  abyte;
  logic [4:0]  hi5;
  logic [5:0]  hi6;
  logic [4:0]  mid5;
  logic [4:0]  pwr_grp;
  logic [5:0]  pwr_adr;
  logic        b23, b22, b15;
  logic        ok;
  result_t     res;

  assign abyte   = frame_data_i[15:8];
  assign hi6     = frame_data_i[22:17];
  assign hi5     = frame_data_i[21:17];
  assign mid5    = frame_data_i[14:10];
  assign pwr_grp = frame_data_i[11:7];
  assign pwr_adr = frame_data_i[5:0];
  assign b23     = frame_data_i[23];
  assign b22     = frame_data_i[22];
  assign b15     = frame_data_i[15];

  always_comb begin
    res = '0;
    ok  = 1'b1;
    if (frame_bits_i == LenForward) begin
      res.frm_kind     = FK_FORWARD;
      res.selector_bit = abyte[0];
      res.payload      = {2'b00, frame_data_i[7:0]};
      if (frame_data_i[31:16] != '0) begin
        ok = 1'b0;
      end else if (abyte >= BcastLow) begin
        res.adr_kind = AK_BCAST;
      end else if (abyte <= ShortMax) begin
        res.adr_kind       = AK_SHORT;
        res.target_address = abyte[6:1];
      end else if (abyte <= GroupMax) begin
        res.adr_kind       = AK_GROUP;
        res.target_address = {2'b00, abyte[4:1]};
      end else begin
        ok = 1'b0;
      end
    end else if (frame_bits_i == LenEvent) begin
      if (frame_data_i[31:24] != '0 || frame_data_i[16]) begin
        ok = 1'b0;
      end else if (frame_data_i[23:13] == PowerTag) begin
        res.frm_kind      = FK_POWER;
        res.source_scheme = SS_POWER;
        if ((!frame_data_i[12] && pwr_grp != '0) || (!frame_data_i[6] && pwr_adr != '0)) begin
          ok = 1'b0;
        end
        if (frame_data_i[12]) begin
          res.present_mask = res.present_mask | MaskGroup;
          res.source_group = pwr_grp;
        end
        if (frame_data_i[6]) begin
          res.present_mask   = res.present_mask | MaskDevice;
          res.source_address = pwr_adr;
        end
      end else begin
        res.frm_kind = FK_EVENT;
        res.payload  = frame_data_i[PayloadW-1:0];
        if (!b23 && !b15) begin
          res.source_scheme  = SS_DEVICE;
          res.present_mask   = MaskDevType;
          res.source_address = hi6;
          res.inst_type      = mid5;
        end else if (!b23) begin
          res.source_scheme   = SS_DEV_INST;
          res.present_mask    = MaskDevInst;
          res.source_address  = hi6;
          res.instance_number = mid5;
        end else if (!b22 && !b15) begin
          res.source_scheme = SS_DEV_GROUP;
          res.present_mask  = MaskGrpType;
          res.source_group  = hi5;
          res.inst_type     = mid5;
        end else if (!b22) begin
          res.source_scheme   = SS_INSTANCE;
          res.present_mask    = MaskInstance;
          res.inst_type       = hi5;
          res.instance_number = mid5;
        end else if (!b15) begin
          res.source_scheme = SS_INST_GROUP;
          res.present_mask  = MaskInstGroup;
          res.source_group  = hi5;
          res.inst_type     = mid5;
        end else begin
          ok = 1'b0;
        end
      end
    end else begin
      ok = 1'b0;
    end

    if (!ok) begin
      res        = '0;
      res.status = 1'b1;
    end
    result_o = res;
  end

endmodule

// File: verif/dfed_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the DALI frame event decoder: decodes every frame transfer on
// its own and compares each result transfer field by field. Depends on dfed_pkg, dfed_if.
module dfed_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfed_frame_if       frame_i,
  dfed_result_if      result_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);
  import dfed_pkg::*;

  result_t     expected_results[$];
  int unsigned fails;

  function automatic result_t classify_frame(input logic [FrameBitsW-1:0] len,
                                             input logic [FrameDataW-1:0] word);
    result_t    r;
    result_t    bad;
    logic [7:0] abyte;
    r          = '0;
    bad        = '0;
    bad.status = 1'b1;
    if (len == LenForward) begin
      if (word[31:16] != '0) return bad;
      abyte            = word[15:8];
      r.frm_kind       = FK_FORWARD;
      r.selector_bit   = abyte[0];
      r.payload        = {2'b00, word[7:0]};
      if (abyte >= BcastLow) begin
        r.adr_kind = AK_BCAST;
      end else if (abyte <= ShortMax) begin
        r.adr_kind       = AK_SHORT;
        r.target_address = abyte[6:1];
      end else if (abyte <= GroupMax) begin
        r.adr_kind       = AK_GROUP;
        r.target_address = {2'b00, abyte[4:1]};
      end else begin
        return bad;
      end
      return r;
    end
    if (len != LenEvent || word[31:24] != '0 || word[16]) return bad;
    if (word[23:13] == PowerTag) begin
      if ((!word[12] && word[11:7] != '0) || (!word[6] && word[5:0] != '0)) return bad;
      r.frm_kind      = FK_POWER;
      r.source_scheme = SS_POWER;
      if (word[12]) begin
        r.present_mask = r.present_mask | MaskGroup;
        r.source_group = word[11:7];
      end
      if (word[6]) begin
        r.present_mask   = r.present_mask | MaskDevice;
        r.source_address = word[5:0];
      end
      return r;
    end
    r.frm_kind = FK_EVENT;
    r.payload  = word[9:0];
    case ({word[23], word[22], word[15]})
      3'b000, 3'b010: begin
        r.source_scheme  = SS_DEVICE;
        r.present_mask   = MaskDevType;
        r.source_address = word[22:17];
        r.inst_type      = word[14:10];
      end
      3'b001, 3'b011: begin
        r.source_scheme   = SS_DEV_INST;
        r.present_mask    = MaskDevInst;
        r.source_address  = word[22:17];
        r.instance_number = word[14:10];
      end
      3'b100: begin
        r.source_scheme = SS_DEV_GROUP;
        r.present_mask  = MaskGrpType;
        r.source_group  = word[21:17];
        r.inst_type     = word[14:10];
      end
      3'b101: begin
        r.source_scheme   = SS_INSTANCE;
        r.present_mask    = MaskInstance;
        r.inst_type       = word[21:17];
        r.instance_number = word[14:10];
      end
      3'b110: begin
        r.source_scheme = SS_INST_GROUP;
        r.present_mask  = MaskInstGroup;
        r.source_group  = word[21:17];
        r.inst_type     = word[14:10];
      end
      default: return bad;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $error("result field %s: expected %0d, got %0d", name, exp, act);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp;
    if (!rst_ni) begin
      expected_results.delete();
      fails = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (frame_i.valid && frame_i.ready) begin
        expected_results.push_back(classify_frame(frame_i.frame_bits, frame_i.frame_data));
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no frame waiting for it");
          fails++;
        end else begin
          exp = expected_results.pop_front();
          check_field("status", exp.status, result_i.status);
          check_field("frm_kind", exp.frm_kind, result_i.frm_kind);
          check_field("adr_kind", exp.adr_kind, result_i.adr_kind);
          check_field("target_address", exp.target_address, result_i.target_address);
          check_field("selector_bit", exp.selector_bit, result_i.selector_bit);
          check_field("payload", exp.payload, result_i.payload);
          check_field("source_scheme", exp.source_scheme, result_i.source_scheme);
          check_field("present_mask", exp.present_mask, result_i.present_mask);
          check_field("source_address", exp.source_address, result_i.source_address);
          check_field("source_group", exp.source_group, result_i.source_group);
          check_field("inst_type", exp.inst_type, result_i.inst_type);
          check_field("instance_number", exp.instance_number, result_i.instance_number);
        end
      end
      error_count_o <= fails;
      pending_o     <= expected_results.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the DALI frame event decoder testbench: clock, reset, frame stimulus and
// result back-pressure. Depends on dfed_pkg, dfed_if, the decoder and dfed_result_checker.
module testbench;
  import dfed_pkg::*;

  localparam int unsigned RandomItems   = 750;
  localparam int unsigned CalmItems     = 150;
  localparam int unsigned HoldOffItem   = 200;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned CycleLimit    = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          gaps_on;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned error_count;
  int unsigned pending;
  int unsigned cycles;

  dfed_frame_if  frame_ch ();
  dfed_result_if result_ch ();

  dali_frame_event_decoder u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_ch),
    .result_o (result_ch)
  );

  dfed_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame_ch),
    .result_i      (result_ch),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_frame(input logic [FrameBitsW-1:0] len,
                            input logic [FrameDataW-1:0] word);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.frame_bits <= len;
    frame_ch.frame_data <= word;
    do @(posedge clk_i); while (!frame_ch.ready);
  endtask

  task automatic random_frame(output logic [FrameBitsW-1:0] len,
                              output logic [FrameDataW-1:0] word);
    int unsigned pick;
    logic [7:0]  abyte;
    pick = $urandom_range(0, 99);
    word = $urandom;
    if (pick < 30) begin
      case ($urandom_range(0, 3))
        0:       abyte = 8'($urandom_range(0, 127));
        1:       abyte = 8'($urandom_range(128, 159));
        2:       abyte = 8'($urandom_range(254, 255));
        default: abyte = 8'($urandom_range(160, 253));
      endcase
      len  = LenForward;
      word = {16'h0000, abyte, word[7:0]};
    end else if (pick < 70) begin
      len        = LenEvent;
      word[31:24] = 8'h00;
      if ($urandom_range(0, 9) != 0) word[16] = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        word[23:13] = PowerTag;
        if ($urandom_range(0, 4) != 0) begin
          if (!word[12]) word[11:7] = '0;
          if (!word[6]) word[5:0] = '0;
        end
      end
    end else if (pick < 85) begin
      len = $urandom_range(0, 1) ? LenForward : LenEvent;
    end else begin
      len = 6'($urandom_range(0, 63));
    end
  endtask

  initial begin
    logic [FrameBitsW-1:0] len;
    logic [FrameDataW-1:0] word;
    rst_ni              = 1'b0;
    gaps_on             = 1'b1;
    hold_req            = 1'b0;
    frame_ch.valid      <= 1'b0;
    frame_ch.frame_bits <= '0;
    frame_ch.frame_data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(LenForward, 32'h0000_0000);
    send_frame(LenForward, 32'h0000_7FFF);
    send_frame(LenForward, 32'h0000_80AA);
    send_frame(LenForward, 32'h0000_9F55);
    send_frame(LenForward, 32'h0000_A000);
    send_frame(LenForward, 32'h0000_FD12);
    send_frame(LenForward, 32'h0000_FE34);
    send_frame(LenForward, 32'h0000_FFFF);
    send_frame(LenForward, 32'h0001_0000);
    send_frame(6'd0, 32'h0000_0000);
    send_frame(6'd63, 32'hFFFF_FFFF);
    send_frame(6'd17, 32'h0000_1234);
    send_frame(LenEvent, 32'h0000_0000);
    send_frame(LenEvent, 32'h007E_FFFF);
    send_frame(LenEvent, 32'h00BE_7FFF);
    send_frame(LenEvent, 32'h00BE_FFFF);
    send_frame(LenEvent, 32'h00FE_7FFF);
    send_frame(LenEvent, 32'h00C0_8000);
    send_frame(LenEvent, 32'h0001_0000);
    send_frame(LenEvent, 32'h0100_0000);
    send_frame(LenEvent, 32'h00FE_E000);
    send_frame(LenEvent, 32'h00FE_FFFF);
    send_frame(LenEvent, 32'h00FE_E05A);
    send_frame(LenEvent, 32'h00FE_E080);
    send_frame(LenEvent, 32'h00FE_E001);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == HoldOffItem) hold_req = 1'b1;
      if (i == RandomItems - CalmItems) gaps_on = 1'b0;
      random_frame(len, word);
      send_frame(len, word);
    end
    frame_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
